>>> src/hse_pkg.sv
package hse_pkg;

    localparam int KEY_PORT_W = 32;

    typedef enum logic [3:0] {
        S_LOAD,
        S_BLD_RD,
        S_BLD_VAL,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_EXT_RD,
        S_EXT_WR,
        S_EMIT_RD,
        S_EMIT_WR
    } t_state;

    typedef struct packed {
        logic take_right;
        logic swap;
    } t_cmp_res;

endpackage

>>> src/hse_in_if.sv
interface hse_in_if;
    logic                            valid;
    logic                            ready;
    logic [hse_pkg::KEY_PORT_W-1:0]  key;
    logic                            last_in;

    modport source (output valid, output key, output last_in, input ready);
    modport sink   (input valid, input key, input last_in, output ready);
endinterface

>>> src/hse_out_if.sv
interface hse_out_if;
    logic                            valid;
    logic                            ready;
    logic [hse_pkg::KEY_PORT_W-1:0]  sorted_key;
    logic                            last_out;
    logic                            overflow;

    modport source (output valid, output sorted_key, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_key, input last_out, input overflow,
                    output ready);
endinterface

>>> src/hse_mem.sv
module hse_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata_a;
    logic [DW-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> src/hse_cmp.sv
module hse_cmp #(
    parameter int KW = 32
) (
    input  logic              i_desc,
    input  logic [KW-1:0]     i_left,
    input  logic [KW-1:0]     i_right,
    input  logic              i_right_ok,
    input  logic [KW-1:0]     i_val,
    output hse_pkg::t_cmp_res o_res,
    output logic [KW-1:0]     o_child
);

    logic w_left_above;
    logic w_child_above;

    // strict "sits higher in the heap" test
    assign w_left_above  = i_desc ? (i_left < i_right) : (i_left > i_right);
    assign o_res.take_right = i_right_ok && !w_left_above;
    assign o_child       = o_res.take_right ? i_right : i_left;
    assign w_child_above = i_desc ? (o_child < i_val) : (o_child > i_val);
    assign o_res.swap    = w_child_above;

endmodule

>>> src/heap_sort_engine_core.sv
// Load: one key per cycle, ready high only while loading.
// Sort of N keys: each sift reads its key, then walks the heap level by level
// (memory read, then compare and write back); a sift ending at a leaf parks its
// key in the read state that finds no child. Emit: keys pass through the output
// register; the next set loads as soon as the final key is registered. Synchronous
// active-low reset clears the sequencer, count, overflow flag and sort order.
module heap_sort_engine_core #(
    parameter int MAX_ITEMS = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_sort_order_we,
    input  logic       i_sort_order,
    hse_in_if.sink     i_in_ch,
    hse_out_if.source  o_out_ch
);

    localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W = CNT_W + 1;
    localparam int KP    = hse_pkg::KEY_PORT_W;

    hse_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_ovf, n_ovf;
    logic                 r_sort_order;
    logic                 r_desc, n_desc;
    logic                 r_build, n_build;
    logic [AW-1:0]        r_idx, n_idx;
    logic [AW-1:0]        r_end, n_end;
    logic [AW-1:0]        r_p, n_p;
    logic [CNT_W-1:0]     r_hn, n_hn;
    logic [KEY_WIDTH-1:0] r_val, n_val;
    logic [CNT_W-1:0]     r_k, n_k;
    logic                 r_out_valid, n_out_valid;
    logic [KP-1:0]        r_out_key, n_out_key;
    logic                 r_out_last, n_out_last;
    logic                 r_out_ovf, n_out_ovf;

    logic                 w_in_acc;
    logic                 w_out_free;
    logic [CNT_W-1:0]     w_cnt_new;
    logic [CNT_W-1:0]     w_bld_tmp;
    logic [IDX_W-1:0]     w_c;
    logic [IDX_W-1:0]     w_c1;
    logic                 w_has_child;
    logic                 w_right_ok;
    logic                 w_emit_last;
    logic [KEY_WIDTH+KP-1:0] w_key_ext;
    logic [KEY_WIDTH+KP-1:0] w_out_ext;
    logic [KEY_WIDTH-1:0] w_key_in;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [KEY_WIDTH-1:0] w_wdata;
    logic                 w_re;
    logic [AW-1:0]        w_raddr_a;
    logic [AW-1:0]        w_raddr_b;
    logic [KEY_WIDTH-1:0] w_rdata_a;
    logic [KEY_WIDTH-1:0] w_rdata_b;

    hse_pkg::t_cmp_res    w_cmp;
    logic [KEY_WIDTH-1:0] w_child;

    hse_mem #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW),
        .DW    (KEY_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_re),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    hse_cmp #(
        .KW (KEY_WIDTH)
    ) u_cmp (
        .i_desc     (r_desc),
        .i_left     (w_rdata_a),
        .i_right    (w_rdata_b),
        .i_right_ok (w_right_ok),
        .i_val      (r_val),
        .o_res      (w_cmp),
        .o_child    (w_child)
    );

    assign i_in_ch.ready       = (r_state == hse_pkg::S_LOAD);
    assign w_in_acc            = i_in_ch.valid && (r_state == hse_pkg::S_LOAD);
    assign w_out_free          = !r_out_valid || o_out_ch.ready;

    assign o_out_ch.valid      = r_out_valid;
    assign o_out_ch.sorted_key = r_out_key;
    assign o_out_ch.last_out   = r_out_last;
    assign o_out_ch.overflow   = r_out_ovf;

    assign w_key_ext  = {{KEY_WIDTH{1'b0}}, i_in_ch.key};
    assign w_key_in   = w_key_ext[KEY_WIDTH-1:0];
    assign w_out_ext  = {{KP{1'b0}}, w_rdata_a};

    assign w_cnt_new  = (r_cnt < CNT_W'(MAX_ITEMS)) ? r_cnt + CNT_W'(1) : r_cnt;
    assign w_bld_tmp  = w_cnt_new - CNT_W'(2);
    assign w_c        = IDX_W'({r_p, 1'b1});
    assign w_c1       = w_c + IDX_W'(1);
    assign w_has_child = w_c < IDX_W'(r_hn);
    assign w_right_ok = w_c1 < IDX_W'(r_hn);
    assign w_emit_last = (r_k + CNT_W'(1)) == r_cnt;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hse_pkg::S_LOAD: begin
                if (w_in_acc && i_in_ch.last_in) begin
                    n_state = (w_cnt_new < CNT_W'(2)) ? hse_pkg::S_EMIT_RD
                                                      : hse_pkg::S_BLD_RD;
                end
            end
            hse_pkg::S_BLD_RD:  n_state = hse_pkg::S_BLD_VAL;
            hse_pkg::S_BLD_VAL: n_state = hse_pkg::S_SIFT_RD;
            hse_pkg::S_SIFT_RD, hse_pkg::S_SIFT_CMP: begin
                if (r_state == hse_pkg::S_SIFT_RD && w_has_child) begin
                    n_state = hse_pkg::S_SIFT_CMP;
                end else if (r_state == hse_pkg::S_SIFT_CMP && w_cmp.swap) begin
                    n_state = hse_pkg::S_SIFT_RD;
                end else if (r_build) begin
                    n_state = (r_idx == '0) ? hse_pkg::S_EXT_RD : hse_pkg::S_BLD_RD;
                end else begin
                    n_state = (r_end == AW'(1)) ? hse_pkg::S_EMIT_RD : hse_pkg::S_EXT_RD;
                end
            end
            hse_pkg::S_EXT_RD:  n_state = hse_pkg::S_EXT_WR;
            hse_pkg::S_EXT_WR:  n_state = hse_pkg::S_SIFT_RD;
            hse_pkg::S_EMIT_RD: n_state = hse_pkg::S_EMIT_WR;
            hse_pkg::S_EMIT_WR: begin
                if (w_out_free) begin
                    n_state = w_emit_last ? hse_pkg::S_LOAD : hse_pkg::S_EMIT_RD;
                end
            end
            default: n_state = hse_pkg::S_LOAD;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_desc      = r_desc;
        n_build     = r_build;
        n_idx       = r_idx;
        n_end       = r_end;
        n_p         = r_p;
        n_hn        = r_hn;
        n_val       = r_val;
        n_k         = r_k;
        n_out_valid = r_out_valid && !o_out_ch.ready;
        n_out_key   = r_out_key;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        w_we        = 1'b0;
        w_waddr     = r_p;
        w_wdata     = r_val;
        w_re        = 1'b0;
        w_raddr_a   = w_c[AW-1:0];
        w_raddr_b   = w_right_ok ? w_c1[AW-1:0] : w_c[AW-1:0];
        case (r_state)
            hse_pkg::S_LOAD: begin
                if (w_in_acc) begin
                    if (r_cnt < CNT_W'(MAX_ITEMS)) begin
                        w_we    = 1'b1;
                        w_waddr = r_cnt[AW-1:0];
                        w_wdata = w_key_in;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_cnt = w_cnt_new;
                    if (i_in_ch.last_in) begin
                        n_desc  = r_sort_order;
                        n_build = 1'b1;
                        n_idx   = AW'(w_bld_tmp >> 1);
                        n_k     = '0;
                    end
                end
            end
            hse_pkg::S_BLD_RD: begin
                w_re      = 1'b1;
                w_raddr_a = r_idx;
            end
            hse_pkg::S_BLD_VAL: begin
                n_val = w_rdata_a;
                n_p   = r_idx;
                n_hn  = r_cnt;
            end
            hse_pkg::S_SIFT_RD, hse_pkg::S_SIFT_CMP: begin
                if (r_state == hse_pkg::S_SIFT_RD && w_has_child) begin
                    w_re = 1'b1;
                end else if (r_state == hse_pkg::S_SIFT_CMP && w_cmp.swap) begin
                    w_we    = 1'b1;
                    w_wdata = w_child;
                    n_p     = w_cmp.take_right ? w_c1[AW-1:0] : w_c[AW-1:0];
                end else begin
                    // sift finished: park the carried key
                    w_we = 1'b1;
                    if (r_build) begin
                        if (r_idx == '0) begin
                            n_build = 1'b0;
                            n_end   = AW'(r_cnt - CNT_W'(1));
                        end else begin
                            n_idx = r_idx - AW'(1);
                        end
                    end else if (r_end == AW'(1)) begin
                        n_k = '0;
                    end else begin
                        n_end = r_end - AW'(1);
                    end
                end
            end
            hse_pkg::S_EXT_RD: begin
                w_re      = 1'b1;
                w_raddr_a = '0;
                w_raddr_b = r_end;
            end
            hse_pkg::S_EXT_WR: begin
                w_we    = 1'b1;
                w_waddr = r_end;
                w_wdata = w_rdata_a;
                n_val   = w_rdata_b;
                n_p     = '0;
                n_hn    = CNT_W'(r_end);
            end
            hse_pkg::S_EMIT_RD: begin
                w_re      = 1'b1;
                w_raddr_a = r_k[AW-1:0];
            end
            hse_pkg::S_EMIT_WR: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_key   = w_out_ext[KP-1:0];
                    n_out_last  = w_emit_last;
                    n_out_ovf   = r_ovf;
                    n_k         = r_k + CNT_W'(1);
                    if (w_emit_last) begin
                        n_cnt = '0;
                        n_ovf = 1'b0;
                    end
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hse_pkg::S_LOAD;
            r_cnt        <= '0;
            r_ovf        <= 1'b0;
            r_sort_order <= 1'b0;
            r_desc       <= 1'b0;
            r_build      <= 1'b0;
            r_idx        <= '0;
            r_end        <= '0;
            r_p          <= '0;
            r_hn         <= '0;
            r_k          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_desc      <= n_desc;
            r_build     <= n_build;
            r_idx       <= n_idx;
            r_end       <= n_end;
            r_p         <= n_p;
            r_hn        <= n_hn;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            if (i_sort_order_we) begin
                r_sort_order <= i_sort_order;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_out_key  <= n_out_key;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

endmodule
